// ===== rtl/cdad_pkg.sv =====
package cdad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADD_W   = 16;
  localparam int OP_W    = 2;
  localparam int WDAY_W  = ADD_W + 1;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR = 14'd1601;
  localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
  localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;
  localparam logic [DAY_W-1:0]   LEAP_FEB   = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // reciprocal of 25 scaled by 2^17; exact for every 14-bit year
  localparam logic [12:0] RECIP_25 = 13'd5243;

  typedef struct packed {
    logic capture_in;
    logic exec;
    logic walk;
    logic emit;
  } cdad_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            walk_more;
    logic            out_free;
  } cdad_status_t;

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [26:0] prod;
    logic [9:0]  q;
    logic [14:0] back;
    logic        div25;
    prod  = y * RECIP_25;
    q     = prod[26:17];
    back  = {1'b0, q, 4'b0} + {2'b0, q, 3'b0} + {5'b0, q};
    div25 = (back == {1'b0, y});
    return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    if (m == FEBRUARY && leap) begin
      return LEAP_FEB;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

// ===== rtl/cdad_ctrl.sv =====
module cdad_ctrl
  import cdad_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  cdad_status_t status,
  output cdad_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_SETTLE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.capture_in = s_tvalid && (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PREP;
      end
      // leap flag of the given year registers during this cycle
      ST_PREP: state_next = ST_EXEC;
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = (status.op == OP_ADD) ? ST_WALK : ST_SETTLE;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!status.walk_more) state_next = ST_SETTLE;
      end
      // let the leap flag follow a year that has just changed
      ST_SETTLE: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/cdad_datapath.sv =====
module cdad_datapath
  import cdad_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cdad_cmd_t          cmd,
  output cdad_status_t       status,
  input  logic [OP_W-1:0]    op_in,
  input  logic [DAY_W-1:0]   day_in,
  input  logic [MONTH_W-1:0] month_in,
  input  logic [YEAR_W-1:0]  year_in,
  input  logic [ADD_W-1:0]   days_to_add,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DAY_W-1:0]   day_out,
  output logic [MONTH_W-1:0] month_out,
  output logic [YEAR_W-1:0]  year_out,
  output logic               is_leap,
  output logic               is_before,
  output logic               error
);

  logic [OP_W-1:0]    in_op;
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [ADD_W-1:0]   in_add;

  logic [DAY_W-1:0]   cur_day;
  logic [MONTH_W-1:0] cur_month;
  logic [YEAR_W-1:0]  cur_year;
  logic [WDAY_W-1:0]  wday;
  logic               leap_cur;
  logic               leap_in;
  logic               earlier;
  logic               err;

  logic [DAY_W-1:0]   len_in;
  logic               load_ok;
  logic               cmp_before;
  logic [DAY_W-1:0]   len_cur;
  logic               over_len;
  logic               at_end;

  assign len_in  = month_days(in_month, leap_in);
  assign load_ok = (in_year != '0) && (in_year <= MAX_YEAR) && (len_in != '0) &&
                   (in_day != '0) && (in_day <= len_in);

  always_comb begin
    if (cur_year != in_year) begin
      cmp_before = (cur_year < in_year);
    end else if (cur_month != in_month) begin
      cmp_before = (cur_month < in_month);
    end else begin
      cmp_before = (cur_day < in_day);
    end
  end

  assign len_cur  = month_days(cur_month, leap_cur);
  assign over_len = (wday > {{(WDAY_W-DAY_W){1'b0}}, len_cur});
  assign at_end   = (cur_month == DECEMBER) && (cur_year >= MAX_YEAR);

  assign status.op        = in_op;
  assign status.walk_more = over_len && !at_end;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    leap_cur <= leap_year(cur_year);
    leap_in  <= leap_year(in_year);
    if (cmd.capture_in) begin
      in_op    <= op_in;
      in_day   <= day_in;
      in_month <= month_in;
      in_year  <= year_in;
      in_add   <= days_to_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= 5'd1;
      cur_month <= JANUARY;
      cur_year  <= RESET_YEAR;
    end else if (cmd.exec) begin
      if (in_op == OP_LOAD && load_ok) begin
        cur_day   <= in_day;
        cur_month <= in_month;
        cur_year  <= in_year;
      end
    end else if (cmd.walk) begin
      if (!over_len) begin
        cur_day <= wday[DAY_W-1:0];
      end else if (at_end) begin
        cur_day <= LAST_DAY;
      end else if (cur_month == DECEMBER) begin
        cur_month <= JANUARY;
        cur_year  <= cur_year + 14'd1;
      end else begin
        cur_month <= cur_month + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      wday    <= {{(WDAY_W-DAY_W){1'b0}}, cur_day} + {1'b0, in_add};
      earlier <= (in_op == OP_COMPARE) && cmp_before;
      err     <= (in_op == OP_LOAD) && !load_ok;
    end else if (cmd.walk) begin
      if (over_len && at_end) begin
        err <= 1'b1;
      end else if (over_len) begin
        wday <= wday - {{(WDAY_W-DAY_W){1'b0}}, len_cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      day_out   <= cur_day;
      month_out <= cur_month;
      year_out  <= cur_year;
      is_leap   <= leap_cur;
      is_before <= earlier;
      error     <= err;
    end
  end

endmodule

// ===== rtl/calendar_date_add_days_unit.sv =====
// Gregorian date register. Each input beat carries an opcode in tuser: load a date
// (rejected with error set if the day, month or year is out of range), add a number of
// days, or report whether the stored date is earlier than the given one. Every beat
// gives one output beat with the stored date, its leap flag, the compare flag and the
// error flag. A load or compare goes through the prep, execute, settle and done states
// to the output beat; an add also walks between execute and settle, at one
// month per cycle (up to about 2150 months for the largest count). The year saturates at
// 31 December 9999 with error set. The next beat is taken once the previous result sits
// in the output register.
module calendar_date_add_days_unit
  import cdad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // day_in[4:0], month_in[8:5], year_in[22:9], days_to_add[38:23], zero[39]
  input  logic [39:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // day_out[4:0], month_out[8:5], year_out[22:9], is_leap[23], is_before[24],
  // error[25], zero[31:26]
  output logic [31:0] m_tdata
);

  cdad_cmd_t    cmd;
  cdad_status_t status;

  logic [DAY_W-1:0]   day_out;
  logic [MONTH_W-1:0] month_out;
  logic [YEAR_W-1:0]  year_out;
  logic               is_leap;
  logic               is_before;
  logic               error;

  cdad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cdad_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op_in       (s_tuser),
    .day_in      (s_tdata[4:0]),
    .month_in    (s_tdata[8:5]),
    .year_in     (s_tdata[22:9]),
    .days_to_add (s_tdata[38:23]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .day_out     (day_out),
    .month_out   (month_out),
    .year_out    (year_out),
    .is_leap     (is_leap),
    .is_before   (is_before),
    .error       (error)
  );

  assign m_tdata = {6'b0, error, is_before, is_leap, year_out, month_out, day_out};

endmodule

// ===== bench/calendar_date_add_days_unit_tb.sv =====
`timescale 1ns / 100ps

module calendar_date_add_days_unit_tb;
  import cdad_pkg::*;

  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               leap;
    logic               earlier;
    logic               err;
  } date_beat_t;

  // Tracks the stored date and holds the date beats still owed by the block.
  class date_ledger;
    int unsigned day_now;
    int unsigned month_now;
    int unsigned year_now;
    int          errors;
    int          mismatches;
    date_beat_t  expected_dates[$];

    function new();
      day_now    = 1;
      month_now  = 1;
      year_now   = int'(RESET_YEAR);
      errors     = 0;
      mismatches = 0;
    endfunction

    static function bit leap_year_of(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned month_length(int unsigned m, int unsigned y);
      if (m < 1 || m > 12) begin
        return 0;
      end
      case (m)
        2:          return leap_year_of(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:    return 31;
      endcase
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    // Apply one accepted command to the tracked date and queue the beat it owes.
    function void take_command(logic [1:0] op, logic [39:0] data);
      int unsigned d;
      int unsigned m;
      int unsigned y;
      int unsigned walk;
      int unsigned len;
      date_beat_t  beat;
      d            = 32'(data[4:0]);
      m            = 32'(data[8:5]);
      y            = 32'(data[22:9]);
      beat.earlier = 1'b0;
      beat.err     = 1'b0;
      case (op)
        OP_LOAD: begin
          len = month_length(m, y);
          if (y < 1 || y > 32'(MAX_YEAR) || len == 0 || d < 1 || d > len) begin
            beat.err = 1'b1;
          end else begin
            day_now   = d;
            month_now = m;
            year_now  = y;
          end
        end
        OP_ADD: begin
          walk = day_now + 32'(data[38:23]);
          len  = month_length(month_now, year_now);
          while (walk > len && !beat.err) begin
            if (month_now == 12 && year_now >= 32'(MAX_YEAR)) begin
              // clamp at the last day the year range allows
              walk     = 31;
              beat.err = 1'b1;
            end else begin
              walk -= len;
              if (month_now == 12) begin
                month_now = 1;
                year_now++;
              end else begin
                month_now++;
              end
              len = month_length(month_now, year_now);
            end
          end
          day_now = walk;
        end
        OP_COMPARE: begin
          if (year_now != y) begin
            beat.earlier = year_now < y;
          end else if (month_now != m) begin
            beat.earlier = month_now < m;
          end else begin
            beat.earlier = day_now < d;
          end
        end
        default: ;
      endcase
      beat.day   = DAY_W'(day_now);
      beat.month = MONTH_W'(month_now);
      beat.year  = YEAR_W'(year_now);
      beat.leap  = leap_year_of(year_now);
      expected_dates.push_back(beat);
    endfunction

    function void check_date_beat(logic [31:0] word);
      date_beat_t got;
      date_beat_t want;
      got.day     = word[4:0];
      got.month   = word[8:5];
      got.year    = word[22:9];
      got.leap    = word[23];
      got.earlier = word[24];
      got.err     = word[25];
      if (expected_dates.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: date beat %h arrived with nothing pending", $time, word);
        end
        return;
      end
      want = expected_dates.pop_front();
      if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
          got.leap !== want.leap || got.earlier !== want.earlier ||
          got.err !== want.err) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected %0d/%0d/%0d leap %b before %b err %b", $time,
                   want.day, want.month, want.year, want.leap, want.earlier, want.err);
          $display("%0t:      got %0d/%0d/%0d leap %b before %b err %b", $time,
                   got.day, got.month, got.year, got.leap, got.earlier, got.err);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  date_ledger board;
  bit         steady = 1'b0;
  int         results_seen = 0;

  calendar_date_add_days_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [39:0] pack_item(int unsigned d, int unsigned m,
                                            int unsigned y, int unsigned add);
    return {1'b0, 16'(add), 14'(y), 4'(m), 5'(d)};
  endfunction

  // Offer one beat, with random gaps ahead of it, and hold it until taken.
  task automatic send_beat(input logic [1:0] op, input logic [39:0] data);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    board.take_command(op, data);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_date_beat(m_tdata);
      results_seen++;
    end
  end

  initial begin : result_sink
    bit held_off;
    int stall_left;
    held_off = 1'b0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 300) begin
        // hold the output long enough for the block to back up into its input
        held_off   = 1'b1;
        stall_left = 600;
        m_tready  <= 1'b0;
        while (stall_left > 0) begin
          @(negedge clk);
          stall_left--;
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d date beats outstanding", board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned d;
    int unsigned mo;
    int unsigned yr;
    int unsigned cnt;
    int unsigned sel;
    int unsigned len;
    logic [1:0]  op;
    board    = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_LOAD;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(OP_COMPARE, pack_item(1, 1, 1601, 0));
    send_beat(OP_LOAD,    pack_item(29, 2, 2000, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 365));
    send_beat(OP_LOAD,    pack_item(29, 2, 1900, 0));
    send_beat(OP_LOAD,    pack_item(29, 2, 2004, 0));
    send_beat(OP_LOAD,    pack_item(0, 5, 2010, 0));
    send_beat(OP_LOAD,    pack_item(31, 4, 2010, 0));
    send_beat(OP_LOAD,    pack_item(1, 0, 2010, 0));
    send_beat(OP_LOAD,    pack_item(1, 13, 2010, 0));
    send_beat(OP_LOAD,    pack_item(31, 15, 16383, 65535));
    send_beat(OP_LOAD,    pack_item(1, 1, 0, 0));
    send_beat(OP_LOAD,    pack_item(1, 1, 10000, 0));
    send_beat(OP_LOAD,    pack_item(28, 2, 2100, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 1));
    send_beat(OP_LOAD,    pack_item(31, 12, 1999, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 1));
    send_beat(OP_LOAD,    pack_item(1, 1, 1, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 65535));
    send_beat(OP_COMPARE, pack_item(31, 15, 16383, 0));
    send_beat(OP_COMPARE, pack_item(0, 0, 0, 65535));
    send_beat(OP_LOAD,    pack_item(31, 12, 9999, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 0));
    send_beat(OP_ADD,     pack_item(0, 0, 0, 1));
    send_beat(OP_NONE,    pack_item(31, 15, 16383, 65535));
    send_beat(OP_LOAD,    pack_item(15, 6, 9990, 0));
    send_beat(OP_ADD,     pack_item(31, 15, 16383, 65535));

    for (int i = 0; i < 1525; i++) begin
      steady = (i >= 900 && i < 1150);
      sel    = $urandom_range(99);
      cnt    = $urandom_range(65535);
      if (sel < 25) begin
        op  = OP_LOAD;
        sel = $urandom_range(9);
        if (sel < 2) begin
          yr = $urandom_range(9990, 9999);
        end else if (sel < 4) begin
          // lean on century years, where the leap rule turns
          yr = 100 * $urandom_range(16, 24) - $urandom_range(0, 4);
        end else begin
          yr = $urandom_range(1, 9999);
        end
        mo  = (sel < 4 && $urandom_range(1)) ? 2 : $urandom_range(1, 12);
        len = date_ledger::month_length(mo, yr);
        d   = $urandom_range(1) ? len - $urandom_range(1) : $urandom_range(1, len);
      end else if (sel < 30) begin
        op = OP_LOAD;
        if ($urandom_range(1)) begin
          d  = $urandom_range(31);
          mo = $urandom_range(15);
          yr = $urandom_range(16383);
        end else begin
          yr = $urandom_range(1, 9999);
          mo = $urandom_range(1, 12);
          d  = $urandom_range(1) ? date_ledger::month_length(mo, yr) + 1 : 0;
        end
      end else if (sel < 70) begin
        op  = OP_ADD;
        d   = $urandom_range(31);
        mo  = $urandom_range(15);
        yr  = $urandom_range(16383);
        sel = $urandom_range(99);
        // keep most walks short; only a few cross thousands of months
        if (sel < 8) begin
          cnt = $urandom_range(65535);
        end else if (sel < 13) begin
          cnt = 0;
        end else if (sel < 30) begin
          cnt = $urandom_range(1, 31);
        end else begin
          cnt = $urandom_range(1, 1500);
        end
      end else if (sel < 95) begin
        op = OP_COMPARE;
        if ($urandom_range(1)) begin
          d   = board.day_now;
          mo  = board.month_now;
          yr  = board.year_now;
          sel = $urandom_range(2);
          case (sel)
            0:       yr = yr + $urandom_range(2) - 1;
            1:       mo = mo + $urandom_range(2) - 1;
            default: d  = d + $urandom_range(2) - 1;
          endcase
        end else begin
          d  = $urandom_range(31);
          mo = $urandom_range(15);
          yr = $urandom_range(16383);
        end
      end else begin
        op = OP_NONE;
        d  = $urandom_range(31);
        mo = $urandom_range(15);
        yr = $urandom_range(16383);
      end
      send_beat(op, pack_item(d, mo, yr, cnt));
    end
    steady = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
